### sv/dtpm_pkg.sv
// Shared types, constants and helpers for the debounced threshold period meter.
package dtpm_pkg;

    // Timestamp and result widths
    localparam int TIME_W   = 32;
    localparam int OUT_W    = 32;
    localparam int SAMPLE_W = 10;
    localparam int HITS_W   = 8;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(32);
    localparam logic [HITS_W-1:0]   DEB_HITS_RST  = HITS_W'(5);

    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [OUT_W-1:0]    t_out;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [HITS_W-1:0]   t_hits;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_DEB_HITS  = 1'b1
    } t_cfg_idx;

    // Item kinds
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Measurement phases; the two spare codes behave as waiting for a fall
    typedef enum logic [2:0] {
        PH_WAIT_FALL = 3'd0,
        PH_DEB_FALL  = 3'd1,
        PH_FALL_DET  = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_DEB_RISE  = 3'd4,
        PH_RISE_DET  = 3'd5
    } t_phase;

    // One input item as held in the input register
    typedef struct packed {
        logic    mode;
        t_sample sample;
    } t_item;

    // One result item
    typedef struct packed {
        t_out period;
        t_out high_ticks;
        t_out low_ticks;
    } t_result;

    // Configuration as seen by the core
    typedef struct packed {
        t_sample threshold;
        t_hits   hit_target;
    } t_cfg;

    // Saturating hit counter increment
    function automatic t_hits bump(input t_hits c);
        if (c == '1) begin
            return c;
        end
        return c + t_hits'(1);
    endfunction

endpackage

### sv/dtpm_in_if.sv
// Input channel: valid/ready handshake carrying one tick or sample item.
interface dtpm_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [dtpm_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

### sv/dtpm_out_if.sv
// Output channel: valid/ready handshake carrying one period measurement.
interface dtpm_out_if;
    logic                        valid;
    logic                        ready;
    logic [dtpm_pkg::OUT_W-1:0]  period;
    logic [dtpm_pkg::OUT_W-1:0]  high_ticks;
    logic [dtpm_pkg::OUT_W-1:0]  low_ticks;

    modport source (output valid, output period, output high_ticks, output low_ticks,
                    input ready);
    modport sink   (input valid, input period, input high_ticks, input low_ticks,
                    output ready);
endinterface

### sv/dtpm_cfg.sv
// Configuration registers: threshold and debounce hit count.
module dtpm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtpm_pkg::CFG_W-1:0]    i_cfg_data,
    output dtpm_pkg::t_cfg                o_cfg
);
    import dtpm_pkg::*;

    t_sample r_threshold;
    t_hits   r_deb_hits;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_deb_hits  <= DEB_HITS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                CFG_DEB_HITS:  r_deb_hits  <= i_cfg_data[HITS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.threshold  = r_threshold;
    assign o_cfg.hit_target = r_deb_hits;

endmodule

### sv/dtpm_in_stage.sv
// Input register stage: holds one item until the core can take it.
module dtpm_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dtpm_pkg::t_item i_item,
    input  logic            i_step,
    output logic            o_valid,
    output dtpm_pkg::t_item o_item
);
    import dtpm_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/dtpm_core.sv
// Phase machine, timestamp and time marks; produces one result per rising mark.
module dtpm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  dtpm_pkg::t_item   i_item,
    input  dtpm_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output dtpm_pkg::t_result o_res
);
    import dtpm_pkg::*;

    t_phase r_phase, n_phase;
    t_hits  r_low_hits, n_low_hits;
    t_hits  r_high_hits, n_high_hits;
    t_time  r_timestamp, n_timestamp;
    t_time  r_fall_mark, n_fall_mark;
    t_time  r_rise_mark, n_rise_mark;
    t_time  r_high_time, n_high_time;

    logic  below;
    t_hits low_bump;
    t_hits high_bump;
    t_time low_t;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT_FALL;
            r_low_hits  <= '0;
            r_high_hits <= '0;
            r_timestamp <= '0;
            r_fall_mark <= '0;
            r_rise_mark <= '0;
            r_high_time <= '0;
        end else begin
            r_phase     <= n_phase;
            r_low_hits  <= n_low_hits;
            r_high_hits <= n_high_hits;
            r_timestamp <= n_timestamp;
            r_fall_mark <= n_fall_mark;
            r_rise_mark <= n_rise_mark;
            r_high_time <= n_high_time;
        end
    end

    assign below     = i_item.sample < i_cfg.threshold;
    assign low_bump  = bump(r_low_hits);
    assign high_bump = bump(r_high_hits);
    // low time runs from the falling mark to now (the rising mark)
    assign low_t     = r_timestamp - r_fall_mark;

    // Result fields, cut or extended to the output width
    assign o_res.period     = OUT_W'(r_high_time + low_t);
    assign o_res.high_ticks = OUT_W'(r_high_time);
    assign o_res.low_ticks  = OUT_W'(low_t);

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_low_hits  = r_low_hits;
        n_high_hits = r_high_hits;
        n_timestamp = r_timestamp;
        n_fall_mark = r_fall_mark;
        n_rise_mark = r_rise_mark;
        n_high_time = r_high_time;
        o_res_valid = 1'b0;

        if (i_step) begin
            if (i_item.mode == MODE_TICK) begin
                n_timestamp = r_timestamp + t_time'(1);
            end else begin
                unique case (r_phase)
                    PH_DEB_FALL: begin
                        if (below) begin
                            n_low_hits = low_bump;
                            if (low_bump >= i_cfg.hit_target) begin
                                n_phase = PH_FALL_DET;
                            end
                        end else begin
                            n_low_hits = '0;
                        end
                    end
                    PH_FALL_DET: begin
                        // sample value ignored; mark the fall
                        n_fall_mark = r_timestamp;
                        n_high_time = r_timestamp - r_rise_mark;
                        n_phase     = PH_WAIT_RISE;
                    end
                    PH_WAIT_RISE: begin
                        if (!below) begin
                            n_phase     = PH_DEB_RISE;
                            n_low_hits  = '0;
                            n_high_hits = t_hits'(1);
                        end
                    end
                    PH_DEB_RISE: begin
                        if (!below) begin
                            n_high_hits = high_bump;
                            if (high_bump >= i_cfg.hit_target) begin
                                n_phase = PH_RISE_DET;
                            end
                        end else begin
                            n_high_hits = '0;
                        end
                    end
                    PH_RISE_DET: begin
                        // sample value ignored; mark the rise and report
                        n_rise_mark = r_timestamp;
                        n_phase     = PH_WAIT_FALL;
                        o_res_valid = 1'b1;
                    end
                    default: begin
                        // waiting for a fall, spare codes included
                        n_phase = PH_WAIT_FALL;
                        if (below) begin
                            n_phase     = PH_DEB_FALL;
                            n_low_hits  = t_hits'(1);
                            n_high_hits = '0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

### sv/dtpm_out_stage.sv
// Result register: holds one measurement until the sink takes it.
module dtpm_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dtpm_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output dtpm_pkg::t_result o_res
);
    import dtpm_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### sv/debounced_threshold_period_meter_top.sv
// A result is loaded into the result register when the core processes the rising-detected sample.
// Throughput: one item per cycle; the input register advances into the core whenever
// the result register is empty or being taken; while a result waits on a stalled sink
// the input register holds one item and input ready stays low.
// Reset: synchronous, active low; phase to waiting for a fall, counters, timestamp and
// marks to zero, threshold to 32 and debounce hits to 5.
module debounced_threshold_period_meter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dtpm_in_if.sink                        i_in,
    dtpm_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [dtpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtpm_pkg::CFG_W-1:0]     i_cfg_data
);
    import dtpm_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    out_valid;

    // Configuration
    dtpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Input register
    assign in_item.mode   = i_in.mode;
    assign in_item.sample = i_in.sample;

    dtpm_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .i_step  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // Process the held item when the result register can take a result
    assign step = held_valid && (!out_valid || o_out.ready);

    dtpm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (held_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    dtpm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_out.valid      = out_valid;
    assign o_out.period     = out_res.period;
    assign o_out.high_ticks = out_res.high_ticks;
    assign o_out.low_ticks  = out_res.low_ticks;

endmodule
